/* rtl/acker_pkg.sv */
// ----------------------------------------------------------------------------
// acker_pkg
// Shared types, constants and tables of the vehicle and motor step block.
// ----------------------------------------------------------------------------
package acker_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int TRIG_ITER_DEF = 16;

    localparam int ACC_W = 68;      // width of exact sums of rounded products
    localparam int CNT_W = 6;       // iteration counter, holds the longest loop
    localparam int PC_W  = 5;       // program counter
    localparam int PROG_LEN = 23;

    localparam logic signed [63:0] PI_Q29          = 64'sd1686629713;
    localparam logic signed [32:0] DEG2RAD_Q32     = 33'sd74961321;
    localparam logic signed [33:0] CORDIC_INV_GAIN = 34'sd652032874;

    localparam logic [30:0] RST_SAMPLE_TIME = 31'd655;
    localparam logic [30:0] RST_GEAR_RATIO  = 31'd65536;
    localparam logic [30:0] RST_INV_WBASE   = 31'd65536;

    typedef enum logic [2:0] {
        REG_SAMPLE_TIME = 3'd0,
        REG_GEAR_RATIO  = 3'd1,
        REG_INV_WBASE   = 3'd2,
        REG_FRIC_INERT  = 3'd3,
        REG_TORQ_INERT  = 3'd4,
        REG_TORQ_IND    = 3'd5,
        REG_RES_IND     = 3'd6,
        REG_INV_IND     = 3'd7
    } t_reg_idx;

    typedef enum logic [4:0] {
        OP_PX, OP_PY, OP_W, OP_TRIG_H, OP_VX, OP_VY, OP_RAD, OP_TRIG_R, OP_DIV,
        OP_WT, OP_HR, OP_HD, OP_A, OP_OM1, OP_K1, OP_OM2, OP_K2, OP_C1, OP_B,
        OP_C2, OP_K3, OP_C3, OP_WH
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [CNT_W-1:0] cnt;
        logic             latch;
        logic             mul;
        logic             acc;
        logic             tinit;
        logic             red;
        logic             fold;
        logic             rot;
        logic             tend;
        logic             dinit;
        logic             div;
        logic             dend;
        logic             load;
    } t_cmd;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] heading;
        logic [31:0] heading_rate;
        logic [31:0] rotor_speed;
        logic [31:0] current;
        logic [31:0] delta_vel_x;
        logic [31:0] delta_vel_y;
        logic [31:0] wheel_speed;
        logic        saturated;
    } t_result;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } t_clamp;

    function automatic int red_steps(input int frac);
        return 31 - frac;
    endfunction

    function automatic int div_bits(input int frac);
        return 34 + frac;
    endfunction

    function automatic int trig_iters(input int n);
        return (n < 24) ? n : 24;
    endfunction

    function automatic t_clamp clamp32(input logic signed [ACC_W-1:0] v);
        t_clamp c;
        c.val = v[31:0];
        c.sat = 1'b0;
        if (v > $signed({{(ACC_W-31){1'b0}}, 31'h7FFF_FFFF})) begin
            c.val = 32'h7FFF_FFFF;
            c.sat = 1'b1;
        end else if (v < $signed({{(ACC_W-31){1'b1}}, 31'h0})) begin
            c.val = 32'h8000_0000;
            c.sat = 1'b1;
        end
        return c;
    endfunction

    function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
        logic signed [33:0] a;
        case (i)
            5'd0:    a = 34'sd843314857;
            5'd1:    a = 34'sd497837830;
            5'd2:    a = 34'sd263043837;
            5'd3:    a = 34'sd133525159;
            5'd4:    a = 34'sd67021687;
            5'd5:    a = 34'sd33543516;
            5'd6:    a = 34'sd16775851;
            5'd7:    a = 34'sd8388437;
            5'd8:    a = 34'sd4194283;
            5'd9:    a = 34'sd2097149;
            5'd10:   a = 34'sd1048576;
            5'd11:   a = 34'sd524288;
            5'd12:   a = 34'sd262144;
            5'd13:   a = 34'sd131072;
            5'd14:   a = 34'sd65536;
            5'd15:   a = 34'sd32768;
            5'd16:   a = 34'sd16384;
            5'd17:   a = 34'sd8192;
            5'd18:   a = 34'sd4096;
            5'd19:   a = 34'sd2048;
            5'd20:   a = 34'sd1024;
            5'd21:   a = 34'sd512;
            5'd22:   a = 34'sd256;
            5'd23:   a = 34'sd128;
            default: a = 34'sd0;
        endcase
        return a;
    endfunction

    function automatic t_op prog_op(input logic [PC_W-1:0] pc);
        t_op o;
        case (pc)
            5'd0:    o = OP_PX;
            5'd1:    o = OP_PY;
            5'd2:    o = OP_W;
            5'd3:    o = OP_TRIG_H;
            5'd4:    o = OP_VX;
            5'd5:    o = OP_VY;
            5'd6:    o = OP_RAD;
            5'd7:    o = OP_TRIG_R;
            5'd8:    o = OP_DIV;
            5'd9:    o = OP_WT;
            5'd10:   o = OP_HR;
            5'd11:   o = OP_HD;
            5'd12:   o = OP_A;
            5'd13:   o = OP_OM1;
            5'd14:   o = OP_K1;
            5'd15:   o = OP_OM2;
            5'd16:   o = OP_K2;
            5'd17:   o = OP_C1;
            5'd18:   o = OP_B;
            5'd19:   o = OP_C2;
            5'd20:   o = OP_K3;
            5'd21:   o = OP_C3;
            5'd22:   o = OP_WH;
            default: o = OP_PX;
        endcase
        return o;
    endfunction

endpackage

/* rtl/acker_ctrl.sv */
// ----------------------------------------------------------------------------
// acker_ctrl
// Sequencer: walks the step program and drives the datapath commands.
// ----------------------------------------------------------------------------
module acker_ctrl #(
    parameter int FRAC_BITS       = acker_pkg::FRAC_BITS_DEF,
    parameter int TRIG_ITERATIONS = acker_pkg::TRIG_ITER_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output acker_pkg::t_cmd   o_cmd
);
    import acker_pkg::*;

    localparam int RED_N = red_steps(FRAC_BITS);
    localparam int ROT_N = trig_iters(TRIG_ITERATIONS);
    localparam int DIV_N = div_bits(FRAC_BITS);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_MUL   = 12'b0000_0000_0010,
        S_ACC   = 12'b0000_0000_0100,
        S_TINIT = 12'b0000_0000_1000,
        S_RED   = 12'b0000_0001_0000,
        S_FOLD  = 12'b0000_0010_0000,
        S_ROT   = 12'b0000_0100_0000,
        S_TEND  = 12'b0000_1000_0000,
        S_DINIT = 12'b0001_0000_0000,
        S_DIV   = 12'b0010_0000_0000,
        S_DEND  = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } t_state;

    t_state           r_state, n_state;
    logic [PC_W-1:0]  r_pc, n_pc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_ovalid, n_ovalid;
    t_state           adv_state;
    logic [PC_W-1:0]  adv_pc;

    function automatic t_state start_of(input t_op op);
        t_state s;
        case (op)
            OP_TRIG_H, OP_TRIG_R: s = S_TINIT;
            OP_DIV:               s = S_DINIT;
            default:              s = S_MUL;
        endcase
        return s;
    endfunction

    // next op of the program, or the hand-over to the output register
    always_comb begin
        adv_pc = PC_W'(r_pc + 1'b1);
        if (r_pc == PC_W'(PROG_LEN - 1)) begin
            adv_state = S_DONE;
        end else begin
            adv_state = start_of(prog_op(adv_pc));
        end
    end

    always_comb begin
        n_state  = r_state;
        n_pc     = r_pc;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid & ~i_out_ready;
        o_cmd    = '0;
        o_cmd.op = prog_op(r_pc);
        o_cmd.cnt = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_pc        = '0;
                    n_state     = start_of(prog_op('0));
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_pc      = adv_pc;
                n_state   = adv_state;
            end
            S_TINIT: begin
                o_cmd.tinit = 1'b1;
                n_cnt       = CNT_W'(RED_N - 1);
                n_state     = S_RED;
            end
            S_RED: begin
                o_cmd.red = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_FOLD;
                end else begin
                    n_cnt = CNT_W'(r_cnt - 1'b1);
                end
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                n_cnt      = '0;
                n_state    = S_ROT;
            end
            S_ROT: begin
                o_cmd.rot = 1'b1;
                if (r_cnt == CNT_W'(ROT_N - 1)) begin
                    n_state = S_TEND;
                end else begin
                    n_cnt = CNT_W'(r_cnt + 1'b1);
                end
            end
            S_TEND: begin
                o_cmd.tend = 1'b1;
                n_pc       = adv_pc;
                n_state    = adv_state;
            end
            S_DINIT: begin
                o_cmd.dinit = 1'b1;
                n_cnt       = '0;
                n_state     = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (r_cnt == CNT_W'(DIV_N - 1)) begin
                    n_state = S_DEND;
                end else begin
                    n_cnt = CNT_W'(r_cnt + 1'b1);
                end
            end
            S_DEND: begin
                o_cmd.dend = 1'b1;
                n_pc       = adv_pc;
                n_state    = adv_state;
            end
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.load = 1'b1;
                    n_ovalid   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pc     <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pc     <= n_pc;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

endmodule

/* rtl/acker_dp.sv */
// ----------------------------------------------------------------------------
// acker_dp
// Datapath: state, registers, shared multiplier, CORDIC and divider.
// ----------------------------------------------------------------------------
module acker_dp #(
    parameter int FRAC_BITS       = acker_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  acker_pkg::t_cmd     i_cmd,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [30:0]         i_cfg_data,
    input  logic [31:0]         i_alpha,
    input  logic [31:0]         i_volt,
    output acker_pkg::t_result  o_result
);
    import acker_pkg::*;

    localparam int DIV_N   = div_bits(FRAC_BITS);
    localparam int TRIG_SH = 30 - FRAC_BITS;

    localparam logic signed [63:0] PI_F =
        (PI_Q29 + (64'sd1 <<< (28 - FRAC_BITS))) >>> (29 - FRAC_BITS);
    localparam logic signed [63:0] HALF_PI_F =
        (PI_Q29 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    localparam logic signed [63:0] TWO_PI_F = 2 * PI_F;
    localparam logic signed [63:0] OFF_F    = (64'sd1 <<< 31) % TWO_PI_F;

    localparam logic signed [33:0] PI_S   = PI_F[33:0];
    localparam logic signed [33:0] HALF_S = HALF_PI_F[33:0];
    localparam logic signed [33:0] TWO_S  = TWO_PI_F[33:0];
    localparam logic signed [33:0] OFF_S  = OFF_F[33:0];
    localparam logic signed [33:0] RND_T  = 34'sd1 <<< (TRIG_SH - 1);
    localparam logic signed [ACC_W-1:0] RND_F = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] RND_32 = ACC_W'(64'sd1 <<< 31);
    localparam logic signed [ACC_W-1:0] ONE_F  = ACC_W'(64'sd1 <<< FRAC_BITS);

    typedef enum logic [3:0] {
        D_POSX, D_POSY, D_W, D_VX, D_VY, D_RAD, D_TMP, D_HR, D_HEAD,
        D_COEF, D_ACC, D_OM, D_CUR, D_WHEEL
    } t_dst;

    // configuration
    logic [30:0] r_dt, r_gam, r_iwb, r_foi, r_toi, r_tind, r_rind, r_iind;

    // vehicle and motor state
    logic [31:0] r_pos_x, r_pos_y, r_vel_x, r_vel_y, r_pvx, r_pvy;
    logic [31:0] r_head, r_hrate, r_rot, r_cur;

    // per-step scratch
    logic [31:0] r_alpha, r_volt, r_w, r_rad, r_tmp, r_coef, r_om, r_tan;
    logic [31:0] r_wheel, r_dvx, r_dvy;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [65:0]      r_prod;
    logic                    r_sat;

    // trig and divide
    logic [31:0]        r_red;
    logic signed [33:0] r_x, r_y, r_z, r_s30, r_c30;
    logic               r_neg;
    logic [33:0]        r_rem;
    logic [DIV_N-1:0]   r_quo;

    t_result r_out;

    function automatic logic signed [ACC_W-1:0] sx(input logic [31:0] v);
        return {{(ACC_W-32){v[31]}}, v};
    endfunction

    // ------------------------------------------------------------ multiply
    logic signed [32:0] opa, opb;
    logic signed [ACC_W-1:0] base;
    logic neg_p, cprod, sh32;
    t_dst dst;
    logic signed [32:0] cos_f, sin_f;
    logic signed [33:0] cos_r, sin_r;

    always_comb begin
        cos_r = (r_c30 + RND_T) >>> TRIG_SH;
        sin_r = (r_s30 + RND_T) >>> TRIG_SH;
        cos_f = cos_r[32:0];
        sin_f = sin_r[32:0];
    end

    always_comb begin
        opa   = {2'b00, r_dt};
        opb   = '0;
        base  = '0;
        neg_p = 1'b0;
        cprod = 1'b0;
        sh32  = 1'b0;
        dst   = D_TMP;
        case (i_cmd.op)
            OP_PX:  begin opb = $signed({r_vel_x[31], r_vel_x}); base = sx(r_pos_x);
                          dst = D_POSX; end
            OP_PY:  begin opb = $signed({r_vel_y[31], r_vel_y}); base = sx(r_pos_y);
                          dst = D_POSY; end
            OP_W:   begin opa = {2'b00, r_gam}; opb = $signed({r_rot[31], r_rot});
                          dst = D_W; end
            OP_VX:  begin opa = $signed({r_w[31], r_w}); opb = cos_f; dst = D_VX; end
            OP_VY:  begin opa = $signed({r_w[31], r_w}); opb = sin_f; dst = D_VY; end
            OP_RAD: begin opa = $signed({r_alpha[31], r_alpha}); opb = DEG2RAD_Q32;
                          sh32 = 1'b1; dst = D_RAD; end
            OP_WT:  begin opa = $signed({r_w[31], r_w}); opb = $signed({r_tan[31], r_tan});
                          dst = D_TMP; end
            OP_HR:  begin opa = $signed({r_tmp[31], r_tmp}); opb = {2'b00, r_iwb};
                          dst = D_HR; end
            OP_HD:  begin opb = $signed({r_hrate[31], r_hrate}); base = sx(r_head);
                          dst = D_HEAD; end
            OP_A:   begin opb = {2'b00, r_foi}; base = ONE_F; neg_p = 1'b1; cprod = 1'b1;
                          dst = D_COEF; end
            OP_OM1: begin opa = $signed({r_coef[31], r_coef}); opb = $signed({r_rot[31], r_rot});
                          dst = D_ACC; end
            OP_K1:  begin opb = {2'b00, r_toi}; dst = D_COEF; end
            OP_OM2: begin opa = $signed({r_coef[31], r_coef}); opb = $signed({r_cur[31], r_cur});
                          base = r_acc; dst = D_OM; end
            OP_K2:  begin opb = {2'b00, r_tind}; dst = D_COEF; end
            OP_C1:  begin opa = $signed({r_coef[31], r_coef}); opb = $signed({r_rot[31], r_rot});
                          neg_p = 1'b1; dst = D_ACC; end
            OP_B:   begin opb = {2'b00, r_rind}; base = ONE_F; neg_p = 1'b1; cprod = 1'b1;
                          dst = D_COEF; end
            OP_C2:  begin opa = $signed({r_coef[31], r_coef}); opb = $signed({r_cur[31], r_cur});
                          base = r_acc; dst = D_ACC; end
            OP_K3:  begin opb = {2'b00, r_iind}; dst = D_COEF; end
            OP_C3:  begin opa = $signed({r_coef[31], r_coef}); opb = $signed({r_volt[31], r_volt});
                          base = r_acc; dst = D_CUR; end
            OP_WH:  begin opa = $signed({r_rot[31], r_rot}); opb = {2'b00, r_gam};
                          dst = D_WHEEL; end
            default: begin end
        endcase
    end

    // ------------------------------------------------------------ round, add, clamp
    logic signed [ACC_W-1:0] pext, fr, pr, sum;
    t_clamp cp, cs, cdx, cdy;
    logic   acc_sat;

    always_comb begin
        pext = {{(ACC_W-66){r_prod[65]}}, r_prod};
        fr   = sh32 ? ((pext + RND_32) >>> 32) : ((pext + RND_F) >>> FRAC_BITS);
        cp   = clamp32(fr);
        pr   = cprod ? sx(cp.val) : fr;
        sum  = base + (neg_p ? -pr : pr);
        cs   = clamp32(sum);
        cdx  = clamp32(sx(r_vel_x) - sx(r_pvx));
        cdy  = clamp32(sx(r_vel_y) - sx(r_pvy));
        acc_sat = (cprod & cp.sat);
        if (dst != D_ACC && dst != D_RAD) begin
            acc_sat = acc_sat | cs.sat;
        end
        if (dst == D_WHEEL) begin
            acc_sat = acc_sat | cdx.sat | cdy.sat;
        end
    end

    // ------------------------------------------------------------ angle reduction
    logic [63:0]        thr;
    logic signed [33:0] rr0, rr1, rr2, rr3, tri_ang;
    logic               fold_neg;

    always_comb begin
        thr = 64'(TWO_PI_F) << i_cmd.cnt;
        rr0 = $signed({2'b00, r_red}) - OFF_S;
        rr1 = (rr0 < 0) ? rr0 + TWO_S : rr0;
        rr2 = (rr1 > PI_S) ? rr1 - TWO_S : rr1;
        rr3 = rr2;
        fold_neg = 1'b0;
        if (rr2 > HALF_S) begin
            rr3 = rr2 - PI_S;
            fold_neg = 1'b1;
        end else if (rr2 < -HALF_S) begin
            rr3 = rr2 + PI_S;
            fold_neg = 1'b1;
        end
        tri_ang = (i_cmd.op == OP_TRIG_H) ? $signed({{2{r_head[31]}}, r_head})
                                          : $signed({{2{r_rad[31]}}, r_rad});
    end

    // ------------------------------------------------------------ CORDIC step
    logic [4:0]         it;
    logic signed [33:0] cdx_s, cdy_s, at;

    always_comb begin
        it    = i_cmd.cnt[4:0];
        cdx_s = r_y >>> it;
        cdy_s = r_x >>> it;
        at    = atan_q30(it);
    end

    // ------------------------------------------------------------ divide step
    logic [34:0]        rem_sh;
    logic [34:0]        dvs;
    logic               ge;
    logic signed [33:0] s_mag;
    logic signed [ACC_W-1:0] qs;
    t_clamp             cq;

    always_comb begin
        rem_sh = {r_rem, r_quo[DIV_N-1]};
        dvs    = {1'b0, r_c30};
        ge     = (rem_sh >= dvs);
        s_mag  = r_s30[33] ? -r_s30 : r_s30;
        qs     = $signed({{(ACC_W-DIV_N){1'b0}}, r_quo});
        if (r_s30[33]) begin
            qs = -qs;
        end
        cq     = clamp32(qs);
    end

    // ------------------------------------------------------------ configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt   <= RST_SAMPLE_TIME;
            r_gam  <= RST_GEAR_RATIO;
            r_iwb  <= RST_INV_WBASE;
            r_foi  <= '0;
            r_toi  <= '0;
            r_tind <= '0;
            r_rind <= '0;
            r_iind <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_SAMPLE_TIME: r_dt   <= i_cfg_data;
                REG_GEAR_RATIO:  r_gam  <= i_cfg_data;
                REG_INV_WBASE:   r_iwb  <= i_cfg_data;
                REG_FRIC_INERT:  r_foi  <= i_cfg_data;
                REG_TORQ_INERT:  r_toi  <= i_cfg_data;
                REG_TORQ_IND:    r_tind <= i_cfg_data;
                REG_RES_IND:     r_rind <= i_cfg_data;
                REG_INV_IND:     r_iind <= i_cfg_data;
                default: begin end
            endcase
        end
    end

    // ------------------------------------------------------------ state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_vel_x <= '0;
            r_vel_y <= '0;
            r_pvx   <= '0;
            r_pvy   <= '0;
            r_head  <= '0;
            r_hrate <= '0;
            r_rot   <= '0;
            r_cur   <= '0;
        end else if (i_cmd.acc) begin
            case (dst)
                D_POSX: r_pos_x <= cs.val;
                D_POSY: r_pos_y <= cs.val;
                D_VX: begin
                    r_pvx   <= r_vel_x;
                    r_vel_x <= cs.val;
                end
                D_VY: begin
                    r_pvy   <= r_vel_y;
                    r_vel_y <= cs.val;
                end
                D_HR:   r_hrate <= cs.val;
                D_HEAD: r_head  <= cs.val;
                D_CUR: begin
                    r_cur <= cs.val;
                    r_rot <= r_om;
                end
                default: begin end
            endcase
        end
    end

    // ------------------------------------------------------------ scratch
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_alpha <= i_alpha;
            r_volt  <= i_volt;
        end
        if (i_cmd.mul) begin
            r_prod <= opa * opb;
        end
        if (i_cmd.latch) begin
            r_sat <= 1'b0;
        end else if (i_cmd.acc) begin
            r_sat <= r_sat | acc_sat;
        end else if (i_cmd.dend) begin
            r_sat <= r_sat | (r_c30 <= 0) | ((r_c30 > 0) & cq.sat);
        end
        if (i_cmd.acc) begin
            case (dst)
                D_W:    r_w    <= cs.val;
                D_RAD:  r_rad  <= sum[31:0];
                D_TMP:  r_tmp  <= cs.val;
                D_COEF: r_coef <= cs.val;
                D_ACC:  r_acc  <= sum;
                D_OM:   r_om   <= cs.val;
                D_WHEEL: begin
                    r_wheel <= cs.val;
                    r_dvx   <= cdx.val;
                    r_dvy   <= cdy.val;
                end
                default: begin end
            endcase
        end
        // angle reduction: offset by half the word range so the word is unsigned
        if (i_cmd.tinit) begin
            r_red <= tri_ang[31:0] ^ 32'h8000_0000;
        end
        if (i_cmd.red && ({32'h0, r_red} >= thr)) begin
            r_red <= r_red - thr[31:0];
        end
        if (i_cmd.fold) begin
            r_x   <= CORDIC_INV_GAIN;
            r_y   <= '0;
            r_z   <= rr3 <<< TRIG_SH;
            r_neg <= fold_neg;
        end
        if (i_cmd.rot) begin
            if (!r_z[33]) begin
                r_x <= r_x - cdx_s;
                r_y <= r_y + cdy_s;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + cdx_s;
                r_y <= r_y - cdy_s;
                r_z <= r_z + at;
            end
        end
        if (i_cmd.tend) begin
            r_s30 <= r_neg ? -r_y : r_y;
            r_c30 <= r_neg ? -r_x : r_x;
        end
        if (i_cmd.dinit) begin
            r_rem <= '0;
            r_quo <= {s_mag, {FRAC_BITS{1'b0}}};
        end
        if (i_cmd.div) begin
            r_rem <= ge ? 34'(rem_sh - dvs) : rem_sh[33:0];
            r_quo <= {r_quo[DIV_N-2:0], ge};
        end
        // tangent at or beyond a quarter turn saturates by sign
        if (i_cmd.dend) begin
            if (r_c30 <= 0) begin
                r_tan <= r_s30[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                r_tan <= cq.val;
            end
        end
        if (i_cmd.load) begin
            r_out.pos_x        <= r_pos_x;
            r_out.pos_y        <= r_pos_y;
            r_out.vel_x        <= r_vel_x;
            r_out.vel_y        <= r_vel_y;
            r_out.heading      <= r_head;
            r_out.heading_rate <= r_hrate;
            r_out.rotor_speed  <= r_rot;
            r_out.current      <= r_cur;
            r_out.delta_vel_x  <= r_dvx;
            r_out.delta_vel_y  <= r_dvy;
            r_out.wheel_speed  <= r_wheel;
            r_out.saturated    <= r_sat;
        end
    end

    assign o_result = r_out;

endmodule

/* rtl/ackermann_vehicle_motor_model_step_top.sv */
// ----------------------------------------------------------------------------
// ackermann_vehicle_motor_model_step_top
// One forward-Euler tick of a bicycle-model vehicle driven by a DC motor.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 word
//  s_axis    in         s_axis_tvalid/tready      steering angle, motor voltage
//  m_axis    out        m_axis_tvalid/tready      new state and derived values
//  cfg       in         i_cfg_we                  ratio register write
//
//  The sequencer steps the work of a word: twenty products through one shared
//  33x33 multiplier, two angle reductions and CORDIC runs, and a
//  one-bit-per-cycle restoring divider for the tangent.
//  Reset clears the state, loads register defaults and empties the output.
//  A finished word waits in the output register; the next input word is
//  taken meanwhile, and the sequencer holds before the output register until
//  the waiting word is gone.
//
module ackermann_vehicle_motor_model_step_top #(
    parameter int FRAC_BITS       = acker_pkg::FRAC_BITS_DEF,
    parameter int TRIG_ITERATIONS = acker_pkg::TRIG_ITER_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] steering_angle_deg, [63:32] motor_voltage
    input  logic [63:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // 32-bit fields from bit 0: out_pos_x, out_pos_y, out_vel_x, out_vel_y,
    // out_heading, out_heading_rate, out_rotor_speed, out_current,
    // delta_vel_x, delta_vel_y, wheel_speed; [352] saturated; rest zero
    output logic [359:0] m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [30:0]  i_cfg_data
);
    import acker_pkg::*;

    t_cmd    cmd;
    t_result res;

    // sequencer: accepts a word, steps the program, hands over to the output
    acker_ctrl #(
        .FRAC_BITS       (FRAC_BITS),
        .TRIG_ITERATIONS (TRIG_ITERATIONS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    // arithmetic, state and output register; the loop lengths live in the sequencer
    acker_dp #(
        .FRAC_BITS       (FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_alpha    (s_axis_tdata[31:0]),
        .i_volt     (s_axis_tdata[63:32]),
        .o_result   (res)
    );

    // pack the result word, first field lowest
    assign m_axis_tdata = {7'b0, res.saturated, res.wheel_speed,
                           res.delta_vel_y, res.delta_vel_x, res.current,
                           res.rotor_speed, res.heading_rate, res.heading,
                           res.vel_y, res.vel_x, res.pos_y, res.pos_x};

endmodule

/* rtl/acker_checker.sv */
// ----------------------------------------------------------------------------
// acker_checker
// Port-level checks of the step block, bound to the top level.
// ----------------------------------------------------------------------------
module acker_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [359:0] m_axis_tdata
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result word changed");

    // an accepted word keeps the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after accept");

    // a result appears only after the block has been busy
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result without work");

endmodule

bind ackermann_vehicle_motor_model_step_top acker_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* test/ackermann_vehicle_motor_model_step_top_test.sv */
// ----------------------------------------------------------------------------
// ackermann_vehicle_motor_model_step_top_test
// Self-checking bench for the vehicle and motor Euler step block: every output
// word is compared field by field with a fixed-point predictor of the model,
// across several ratio register settings and with random stalls on both sides.
// ----------------------------------------------------------------------------
module ackermann_vehicle_motor_model_step_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import acker_pkg::*;

    localparam int  FRAC       = 16;
    localparam int  ITERS      = 16;
    localparam int  WORD_GAP   = 170;       // settle wait at the end of drain
    localparam int  STALL_LIM  = 12000;     // cycles without any word moving
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata;     // [31:0] steering_angle_deg, [63:32] motor_voltage
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [359:0] m_axis_tdata;     // eleven 32-bit state/derived fields, [352] saturated
    logic         i_cfg_we;
    logic [2:0]   i_cfg_idx;
    logic [30:0]  i_cfg_data;

    ackermann_vehicle_motor_model_step_top DUT (.*);

    // ---- predictor state -------------------------------------------------
    longint ratio_reg [8];
    longint px, py, vx, vy, pvx, pvy, hd, hr, om, cur;
    bit     clamp_hit;

    t_result step_queue [$];

    int     errors;
    int     words_out;
    int     idle_cycles;
    bit     hold_off;          // long receiver hold-off request
    int     atan_tab [24] = '{843314857, 497837830, 263043837, 133525159, 67021687,
                              33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
                              524288, 262144, 131072, 65536, 32768, 16384, 8192,
                              4096, 2048, 1024, 512, 256, 128};

    // floor shift on a signed value
    function automatic longint fl_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint sat32(longint v);
        if (v > S32_MAX) begin
            clamp_hit = 1;
            return S32_MAX;
        end
        if (v < S32_MIN) begin
            clamp_hit = 1;
            return S32_MIN;
        end
        return v;
    endfunction

    // exact product then round to nearest, ties up; operands are at most 33 bit
    function automatic longint qmul(longint a, longint b);
        logic signed [95:0] p;
        p = 96'(a) * 96'(b) + (96'sd1 <<< (FRAC - 1));
        p = p >>> FRAC;
        return longint'(p);
    endfunction

    // result bus, first field lowest, into the struct layout
    function automatic t_result unpack_word(input logic [359:0] d);
        t_result r;
        r = '0;
        for (int f = 0; f < 11; f++)
            r[352-32*f -: 32] = d[32*f +: 32];
        r.saturated = d[352];
        return r;
    endfunction

    // sine and cosine at 30 fraction bits of a Q16 angle
    task automatic sin_cos30(input longint ang, output longint s30, output longint c30);
        longint pi_f, half_pi, two_pi, r, x, y, z, dx, dy;
        bit flip;
        pi_f    = (1686629713 + (64'sd1 << (28 - FRAC))) >>> (29 - FRAC);
        half_pi = (1686629713 + (64'sd1 << (29 - FRAC))) >>> (30 - FRAC);
        two_pi  = 2 * pi_f;
        r = ang % two_pi;
        flip = 0;
        if (r < 0) r += two_pi;
        if (r > pi_f) r -= two_pi;
        if (r > half_pi) begin
            r -= pi_f;
            flip = 1;
        end else if (r < -half_pi) begin
            r += pi_f;
            flip = 1;
        end
        x = 652032874;
        y = 0;
        z = r * (64'sd1 << (30 - FRAC));
        for (int i = 0; i < ITERS && i < 24; i++) begin
            dx = fl_shift(y, i);
            dy = fl_shift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        s30 = y;
        c30 = x;
    endtask

    function automatic longint to_q16(longint v30);
        return fl_shift(v30 + (64'sd1 << (30 - FRAC - 1)), 30 - FRAC);
    endfunction

    // advance the vehicle and motor one tick and queue the expected word
    task automatic predict_step(input logic [31:0] angle_w, input logic [31:0] volt_w);
        longint alpha, volt, dt, gam, w, s30, c30, rad, tn, a, b, nom, ncur;
        logic signed [95:0] dq;
        t_result r;
        alpha = longint'($signed(angle_w));
        volt  = longint'($signed(volt_w));
        dt    = ratio_reg[REG_SAMPLE_TIME];
        gam   = ratio_reg[REG_GEAR_RATIO];
        clamp_hit = 0;

        px  = sat32(px + qmul(dt, vx));
        py  = sat32(py + qmul(dt, vy));
        pvx = vx;
        pvy = vy;

        w = sat32(qmul(gam, om));
        sin_cos30(hd, s30, c30);
        vx = sat32(qmul(w, to_q16(c30)));
        vy = sat32(qmul(w, to_q16(s30)));

        dq  = 96'(alpha) * 96'sd74961321 + (96'sd1 <<< 31);
        rad = longint'(dq >>> 32);
        sin_cos30(rad, s30, c30);
        if (c30 <= 0) begin
            clamp_hit = 1;
            tn = (s30 >= 0) ? S32_MAX : S32_MIN;
        end else begin
            tn = sat32((s30 * (64'sd1 << FRAC)) / c30);
        end
        hr = sat32(qmul(sat32(qmul(w, tn)), ratio_reg[REG_INV_WBASE]));
        hd = sat32(hd + qmul(dt, hr));

        a    = sat32((64'sd1 << FRAC) - sat32(qmul(dt, ratio_reg[REG_FRIC_INERT])));
        nom  = sat32(qmul(a, om) + qmul(sat32(qmul(dt, ratio_reg[REG_TORQ_INERT])), cur));
        b    = sat32((64'sd1 << FRAC) - sat32(qmul(dt, ratio_reg[REG_RES_IND])));
        ncur = sat32(-qmul(sat32(qmul(dt, ratio_reg[REG_TORQ_IND])), om)
                     + qmul(b, cur)
                     + qmul(sat32(qmul(dt, ratio_reg[REG_INV_IND])), volt));
        om  = nom;
        cur = ncur;

        r.pos_x        = px[31:0];
        r.pos_y        = py[31:0];
        r.vel_x        = vx[31:0];
        r.vel_y        = vy[31:0];
        r.heading      = hd[31:0];
        r.heading_rate = hr[31:0];
        r.rotor_speed  = om[31:0];
        r.current      = cur[31:0];
        r.delta_vel_x  = 32'(sat32(vx - pvx));
        r.delta_vel_y  = 32'(sat32(vy - pvy));
        r.wheel_speed  = 32'(sat32(qmul(om, gam)));
        r.saturated    = clamp_hit;
        step_queue.push_back(r);
    endtask

    // ---- clock and watchdog ----------------------------------------------
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIM) begin
            $display("%0t: watchdog, no word moved for %0d cycles", $time, idle_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // ---- receiver: random stalls, long hold-off on request ---------------
    initial begin
        int wait_n;
        m_axis_tready <= 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                m_axis_tready <= 0;
                repeat (2000) @(posedge i_clk);
                hold_off = 0;
            end
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (wait_n > 0) begin
                m_axis_tready <= 0;
                repeat (wait_n) @(posedge i_clk);
            end
            m_axis_tready <= 1;
            @(posedge i_clk iff m_axis_tvalid);
        end
    end

    // ---- checker: compare each accepted word with the oldest expectation -
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = unpack_word(m_axis_tdata);
            words_out++;
            if (step_queue.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
            end else begin
                want = step_queue.pop_front();
                for (int f = 0; f < 11; f++)
                    if (got[352-32*f -: 32] !== want[352-32*f -: 32]) begin
                        $display("%0t: field %0d expected %h actual %h", $time, f,
                                 want[352-32*f -: 32], got[352-32*f -: 32]);
                        errors++;
                    end
                if (got.saturated !== want.saturated) begin
                    $display("%0t: saturated expected %b actual %b", $time,
                             want.saturated, got.saturated);
                    errors++;
                end
            end
        end
    end

    // ---- stimulus helpers ------------------------------------------------
    // valid stays up after an accept; a gap in the next call or drain takes it down
    task automatic send_tick(input logic [31:0] angle_w, input logic [31:0] volt_w,
                             input bit gaps = 1);
        int gap;
        gap = (gaps && $urandom_range(0, 3) != 0) ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {volt_w, angle_w};
        @(posedge i_clk iff s_axis_tready);
        predict_step(angle_w, volt_w);
    endtask

    // pause until every expected word has arrived, then let the block settle
    task automatic drain;
        s_axis_tvalid <= 0;
        while (step_queue.size() != 0) @(posedge i_clk);
        repeat (WORD_GAP) @(posedge i_clk);
    endtask

    task automatic write_ratio(input t_reg_idx idx, input logic [30:0] val);
        i_cfg_we   <= 1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 0;
        ratio_reg[idx] = longint'(val);
        @(posedge i_clk);
    endtask

    // typical vehicle values, small enough that most ticks stay unclamped
    task automatic load_plausible;
        write_ratio(REG_SAMPLE_TIME, 31'($urandom_range(100, 6554)));
        write_ratio(REG_GEAR_RATIO,  31'($urandom_range(1000, 300000)));
        write_ratio(REG_INV_WBASE,   31'($urandom_range(10000, 300000)));
        write_ratio(REG_FRIC_INERT,  31'($urandom_range(0, 200000)));
        write_ratio(REG_TORQ_INERT,  31'($urandom_range(0, 2000000)));
        write_ratio(REG_TORQ_IND,    31'($urandom_range(0, 2000000)));
        write_ratio(REG_RES_IND,     31'($urandom_range(0, 2000000)));
        write_ratio(REG_INV_IND,     31'($urandom_range(0, 5000000)));
    endtask

    function automatic logic [31:0] rand_angle();
        case ($urandom_range(0, 4))
            0:       return $urandom();
            1:       return 32'($signed($urandom_range(0, 180 << 16)) - (90 << 16));
            2:       return 32'(($urandom_range(0, 1) ? 90 : -90) << 16) ^ $urandom_range(0, 3);
            default: return 32'($signed($urandom_range(0, 60 << 16)) - (30 << 16));
        endcase
    endfunction

    function automatic logic [31:0] rand_volt();
        if ($urandom_range(0, 5) == 0)
            return $urandom();
        return 32'($signed($urandom_range(0, 48 << 16)) - (24 << 16));
    endfunction

    // ---- tests -----------------------------------------------------------
    // Reset defaults, then field extremes and the tangent corner cases.
    task automatic test_directed;
        logic [31:0] angles [12] = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h005A_0000,
                                     32'hFFA6_0000, 32'h00B4_0000, 32'h010E_0000,
                                     32'h0059_FFFF, 32'h001E_0000, 32'hFFE2_0000,
                                     32'h0000_0001, 32'hFFFF_FFFF};
        send_tick(32'h0, 32'h0);
        drain();
        write_ratio(REG_TORQ_INERT, 31'd65536);
        write_ratio(REG_INV_IND,    31'd65536);
        write_ratio(REG_RES_IND,    31'd6554);
        for (int k = 0; k < 12; k++)
            send_tick(angles[k], (k % 2) ? 32'h7FFF_FFFF : 32'h0003_0000);
        send_tick(32'h0, 32'h8000_0000);
        send_tick(32'h0, 32'hFFFF_FFFF);
        drain();
    endtask

    // Register extremes: all-ones drives every coefficient into clamping, then all zeros.
    task automatic test_extreme_ratios;
        for (int r = 0; r < 8; r++)
            write_ratio(t_reg_idx'(r), 31'h7FFF_FFFF);
        for (int k = 0; k < 40; k++)
            send_tick($urandom(), $urandom());
        drain();
        for (int r = 0; r < 8; r++)
            write_ratio(t_reg_idx'(r), 31'd0);
        for (int k = 0; k < 20; k++)
            send_tick($urandom(), $urandom());
        drain();
    endtask

    // Random driving with plausible coefficients, regime changes in between.
    task automatic test_random_drive(input int n_ticks);
        for (int k = 0; k < n_ticks; k++) begin
            if (k % 300 == 0) begin
                drain();
                load_plausible();
            end
            send_tick(rand_angle(), rand_volt());
        end
        drain();
    endtask

    // Back pressure: receiver holds off while words keep coming, then a full pause.
    task automatic test_back_pressure;
        hold_off = 1;
        for (int k = 0; k < 30; k++)
            send_tick(rand_angle(), rand_volt(), 0);
        drain();
        for (int k = 0; k < 50; k++)
            send_tick(rand_angle(), rand_volt(), 0);
        drain();
    endtask

    initial begin
        errors = 0;
        words_out = 0;
        idle_cycles = 0;
        hold_off = 0;
        ratio_reg = '{655, 65536, 65536, 0, 0, 0, 0, 0};
        {px, py, vx, vy, pvx, pvy, hd, hr, om, cur} = '0;
        i_rst_n       <= 0;
        s_axis_tvalid <= 0;
        s_axis_tdata  <= '0;
        i_cfg_we      <= 0;
        i_cfg_idx     <= REG_SAMPLE_TIME;
        i_cfg_data    <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        test_directed();
        test_extreme_ratios();
        test_back_pressure();
        test_random_drive(1495);

        $display("Covered %0d output words over reset, extreme and random ratio settings,",
                 words_out);
        $display("tangent corners, clamping and long output back pressure.");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
